// ===== src/rbsi_pkg.sv =====
// Shared types and constants of the ray and box slab intersection block.
package rbsi_pkg;

  localparam int unsigned QW        = 32;  // width of every Q value
  localparam int unsigned NW        = 33;  // corner minus origin, signed
  localparam int unsigned MW        = 33;  // magnitude of numerator or divisor
  localparam int unsigned DIV_STEPS = 32;  // one quotient bit per stage
  localparam int unsigned DIV_LAT   = DIV_STEPS + 3;
  localparam int unsigned SEL_LAT   = 3;
  localparam int unsigned CFG_IW    = 3;

  localparam logic [CFG_IW-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_BOX_MAX_Z = 3'd5;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  // Side information that travels with a quotient through the divider.
  typedef struct packed {
    logic neg;    // result sign when nothing saturates
    logic dzero;  // divisor is zero
    logic npos;   // numerator above zero
    logic nneg;   // numerator below zero
    logic ovf;    // quotient magnitude is 2^32 or more
  } div_flags_t;

endpackage

// ===== src/rbsi_if.sv =====
// Channel interfaces for ray beats in and hit beats out.
interface rbsi_ray_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] direction_x;
  logic signed [31:0] direction_y;
  logic signed [31:0] direction_z;
  logic signed [31:0] far_limit;

  modport source (output valid, origin_x, origin_y, origin_z, direction_x,
                  direction_y, direction_z, far_limit, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, direction_x,
                direction_y, direction_z, far_limit, output ready);
endinterface

interface rbsi_hit_if;
  logic               valid;
  logic               ready;
  logic               hit_flag;
  logic signed [31:0] hit_distance;

  modport source (output valid, hit_flag, hit_distance, input ready);
  modport sink (input valid, hit_flag, hit_distance, output ready);
endinterface

// ===== src/ray_box_slab_intersect.sv =====
// Top level of the ray against axis-aligned box slab intersection block.
// Takes one ray beat per cycle and returns one hit beat per ray, in order.
// Most of the pipeline is the six parallel dividers, which resolve one
// quotient bit per pipeline stage. The whole pipeline advances together
// and stalls only while a finished beat waits at the output. Box corners
// are to be written through the configuration port while no ray is in
// flight; the block itself does not enforce this, the user must.
module ray_box_slab_intersect #(
  parameter int unsigned EPSILON_LSBS = 1,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rbsi_ray_if.sink                    ray_in,
  rbsi_hit_if.source                  hit_out,
  input  logic                        cfg_we_i,
  input  logic [rbsi_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [rbsi_pkg::QW-1:0]     cfg_data_i
);
  import rbsi_pkg::*;

  localparam int unsigned VLAT = 1 + DIV_LAT + SEL_LAT;

  logic signed [QW-1:0] box_lo_q [3];
  logic signed [QW-1:0] box_hi_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_lo_q[i] <= '0;
        box_hi_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_MIN_X: box_lo_q[0] <= cfg_data_i;
        REG_BOX_MIN_Y: box_lo_q[1] <= cfg_data_i;
        REG_BOX_MIN_Z: box_lo_q[2] <= cfg_data_i;
        REG_BOX_MAX_X: box_hi_q[0] <= cfg_data_i;
        REG_BOX_MAX_Y: box_hi_q[1] <= cfg_data_i;
        REG_BOX_MAX_Z: box_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [VLAT-1:0] valid_q;
  logic            en;

  assign en           = !valid_q[VLAT-1] || hit_out.ready;
  assign ray_in.ready = en;
  assign hit_out.valid = valid_q[VLAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[VLAT-2:0], ray_in.valid};
    end
  end

  // Entry stage: numerators and biased divisors.
  logic signed [QW-1:0] org [3];
  logic signed [QW-1:0] dir [3];
  assign org[0] = ray_in.origin_x;
  assign org[1] = ray_in.origin_y;
  assign org[2] = ray_in.origin_z;
  assign dir[0] = ray_in.direction_x;
  assign dir[1] = ray_in.direction_y;
  assign dir[2] = ray_in.direction_z;

  logic signed [NW-1:0] num_lo_q [3];
  logic signed [NW-1:0] num_hi_q [3];
  logic signed [NW-1:0] den_q    [3];
  logic signed [QW-1:0] far_q    [0:DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_lo_q[i] <= NW'(box_lo_q[i]) - NW'(org[i]);
        num_hi_q[i] <= NW'(box_hi_q[i]) - NW'(org[i]);
        den_q[i]    <= NW'(dir[i]) + NW'(EPSILON_LSBS);
      end
      far_q[0] <= ray_in.far_limit;
      for (int s = 1; s <= DIV_LAT; s++) begin
        far_q[s] <= far_q[s-1];
      end
    end
  end

  logic signed [QW-1:0] t_lo [3];
  logic signed [QW-1:0] t_hi [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_lo_q[a]),
      .den_i (den_q[a]),
      .quo_o (t_lo[a])
    );
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_hi_q[a]),
      .den_i (den_q[a]),
      .quo_o (t_hi[a])
    );
  end

  rbsi_sel u_sel (
    .clk_i          (clk_i),
    .en_i           (en),
    .t_lo_i         (t_lo),
    .t_hi_i         (t_hi),
    .limit_i        (far_q[DIV_LAT]),
    .hit_flag_o     (hit_out.hit_flag),
    .hit_distance_o (hit_out.hit_distance)
  );

endmodule

// ===== src/rbsi_div.sv =====
// Pipelined saturating fixed-point divider, one quotient bit per stage.
module rbsi_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [rbsi_pkg::NW-1:0]  num_i,
  input  logic signed [rbsi_pkg::NW-1:0]  den_i,
  output logic signed [rbsi_pkg::QW-1:0]  quo_o
);
  import rbsi_pkg::*;

  localparam int unsigned CW = MW + FRAC_BITS;
  localparam int unsigned RW = MW + 1;
  localparam int unsigned OW = MW + QW;

  // Prep stage.
  logic [MW-1:0] nmag_q, dmag_p_q;
  div_flags_t    pflags_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_q         <= num_i[NW-1] ? MW'(-num_i) : MW'(num_i);
      dmag_p_q       <= den_i[NW-1] ? MW'(-den_i) : MW'(den_i);
      pflags_q.neg   <= num_i[NW-1] ^ den_i[NW-1];
      pflags_q.dzero <= (den_i == '0);
      pflags_q.npos  <= !num_i[NW-1] && (num_i != '0);
      pflags_q.nneg  <= num_i[NW-1];
      pflags_q.ovf   <= 1'b0;
    end
  end

  // Iteration stages: index 0 is the overflow check stage output.
  logic [MW-1:0]   rem_q   [0:DIV_STEPS];
  logic [QW-1:0]   low_q   [0:DIV_STEPS];
  logic [QW-1:0]   quo_q   [0:DIV_STEPS];
  logic [MW-1:0]   dmag_q  [0:DIV_STEPS];
  div_flags_t      flags_q [0:DIV_STEPS];

  logic [CW-1:0] shifted;
  assign shifted = CW'(nmag_q) << FRAC_BITS;

  // The quotient needs more than 32 bits when nmag * 2^FRAC >= dmag * 2^32.
  div_flags_t flags0_d;
  always_comb begin
    flags0_d     = pflags_q;
    flags0_d.ovf = (OW'(nmag_q) << FRAC_BITS) >= (OW'(dmag_p_q) << QW);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= MW'(nmag_q >> (QW - FRAC_BITS));
      low_q[0]   <= shifted[QW-1:0];
      quo_q[0]   <= '0;
      dmag_q[0]  <= dmag_p_q;
      flags_q[0] <= flags0_d;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          take;
    assign trial = {rem_q[k], low_q[k][QW-1]};
    assign take  = trial >= RW'(dmag_q[k]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]   <= take ? MW'(trial - RW'(dmag_q[k])) : MW'(trial);
        low_q[k+1]   <= low_q[k] << 1;
        quo_q[k+1]   <= {quo_q[k][QW-2:0], take};
        dmag_q[k+1]  <= dmag_q[k];
        flags_q[k+1] <= flags_q[k];
      end
    end
  end

  // Saturation and sign.
  div_flags_t      ff;
  logic [QW-1:0]   qm;
  logic signed [QW-1:0] res_d, res_q;
  assign ff = flags_q[DIV_STEPS];
  assign qm = quo_q[DIV_STEPS];

  always_comb begin
    if (ff.dzero) begin
      res_d = ff.npos ? Q_MAX : (ff.nneg ? Q_MIN : '0);
    end else if (ff.ovf) begin
      res_d = ff.neg ? Q_MIN : Q_MAX;
    end else if (ff.neg) begin
      res_d = qm[QW-1] ? Q_MIN : -$signed(qm);
    end else begin
      res_d = qm[QW-1] ? Q_MAX : $signed(qm);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign quo_o = res_q;

endmodule

// ===== src/rbsi_sel.sv =====
// Slab ordering, entry and exit reduction, and the hit decision.
module rbsi_sel (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [rbsi_pkg::QW-1:0] t_lo_i [3],
  input  logic signed [rbsi_pkg::QW-1:0] t_hi_i [3],
  input  logic signed [rbsi_pkg::QW-1:0] limit_i,
  output logic                           hit_flag_o,
  output logic signed [rbsi_pkg::QW-1:0] hit_distance_o
);
  import rbsi_pkg::*;

  logic signed [QW-1:0] near_q [3];
  logic signed [QW-1:0] far_q  [3];
  logic signed [QW-1:0] lim1_q, lim2_q;
  logic signed [QW-1:0] entry_q, exit_q;
  logic signed [QW-1:0] entry_d, exit_d;
  logic                 hit_d, hit_q;
  logic signed [QW-1:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        near_q[i] <= (t_lo_i[i] > t_hi_i[i]) ? t_hi_i[i] : t_lo_i[i];
        far_q[i]  <= (t_lo_i[i] > t_hi_i[i]) ? t_lo_i[i] : t_hi_i[i];
      end
      lim1_q <= limit_i;
    end
  end

  always_comb begin
    entry_d = near_q[0];
    exit_d  = far_q[0];
    for (int i = 1; i < 3; i++) begin
      if (near_q[i] > entry_d) entry_d = near_q[i];
      if (far_q[i] < exit_d) exit_d = far_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
      exit_q  <= exit_d;
      lim2_q  <= lim1_q;
    end
  end

  always_comb begin
    if (exit_q < entry_q) begin
      hit_d = 1'b0;
    end else if (exit_q > 0) begin
      hit_d = !(entry_q > lim2_q);
    end else begin
      hit_d = (entry_q >= 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= hit_d;
      dist_q <= hit_d ? entry_q : '0;
    end
  end

  assign hit_flag_o     = hit_q;
  assign hit_distance_o = dist_q;

endmodule

// ===== src/rbsi_chk.sv =====
// Port-level checks of the slab intersection block and their binding.
module rbsi_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit_flag,
  input logic [31:0] hit_distance
);

  // A miss always reports a zero distance.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !hit_flag |-> hit_distance == 32'd0)
    else $error("miss beat carries a nonzero distance");

  // Input is held off exactly while a finished beat is stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // A stalled result beat keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(hit_flag)
      && $stable(hit_distance))
    else $error("stalled result beat changed");

  // Results never appear in the cycle right after reset.
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind ray_box_slab_intersect rbsi_chk u_rbsi_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready     (ray_in.ready),
  .out_valid    (hit_out.valid),
  .out_ready    (hit_out.ready),
  .hit_flag     (hit_out.hit_flag),
  .hit_distance (hit_out.hit_distance)
);

// ===== tb/tb_ray_box_slab_intersect.sv =====
// Testbench for the ray and box slab intersection block: predicted hits checked beat by beat.
module tb_ray_box_slab_intersect;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsi_pkg::*;

  localparam int EPS = 1;
  localparam int FRAC = 16;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz, lim;
  } ray_t;
  typedef struct packed {
    logic hit;
    logic signed [31:0] distance;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [QW-1:0] cfg_data_i = '0;

  rbsi_ray_if ray_ch ();
  rbsi_hit_if hit_ch ();

  ray_box_slab_intersect #(.EPSILON_LSBS(EPS), .FRAC_BITS(FRAC)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .ray_in(ray_ch.sink), .hit_out(hit_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  hit_t pending_hits [$];
  int errors = 0;
  int rays_sent = 0;
  int hits_seen = 0;
  int hit_count = 0;
  bit quiet = 1'b0;  // no idling on either side
  longint cycles = 0;

  initial begin
    ray_ch.valid = 1'b0;
    {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} = '0;
    {ray_ch.direction_x, ray_ch.direction_y, ray_ch.direction_z} = '0;
    ray_ch.far_limit = '0;
    hit_ch.ready = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint slab_quot(longint num, longint den);
    longint q, an, ad;
    if (den == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = (an <<< FRAC) / ad;
    if ((num < 0) != (den < 0)) return q > 64'sd2147483648 ? -64'sd2147483648 : -q;
    return q > 64'sd2147483647 ? 64'sd2147483647 : q;
  endfunction

  function automatic hit_t predict_hit(ray_t r);
    longint o [3], d [3];
    longint a, b, entry, leave;
    hit_t h;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = longint'(r.dx) + EPS; d[1] = longint'(r.dy) + EPS; d[2] = longint'(r.dz) + EPS;
    entry = -64'sd9000000000;
    leave = 64'sd9000000000;
    for (int i = 0; i < 3; i++) begin
      a = slab_quot(longint'(box_lo[i]) - o[i], d[i]);
      b = slab_quot(longint'(box_hi[i]) - o[i], d[i]);
      if (a > b) begin
        entry = b > entry ? b : entry;
        leave = a < leave ? a : leave;
      end else begin
        entry = a > entry ? a : entry;
        leave = b < leave ? b : leave;
      end
    end
    if (leave < entry) h.hit = 1'b0;
    else if (leave > 0) h.hit = !(entry > longint'(r.lim));
    else h.hit = entry >= 0;
    h.distance = h.hit ? entry[31:0] : '0;
    return h;
  endfunction

  task automatic write_corner(logic [CFG_IW-1:0] idx, logic signed [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BOX_MIN_X: box_lo[0] = val;
      REG_BOX_MIN_Y: box_lo[1] = val;
      REG_BOX_MIN_Z: box_lo[2] = val;
      REG_BOX_MAX_X: box_hi[0] = val;
      REG_BOX_MAX_Y: box_hi[1] = val;
      default:       box_hi[2] = val;
    endcase
  endtask

  task automatic drain();
    ray_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DIV_LAT + SEL_LAT + 6) @(posedge clk_i);
  endtask

  task automatic set_box(logic signed [31:0] lx, ly, lz, hx, hy, hz);
    drain();
    write_corner(REG_BOX_MIN_X, lx);
    write_corner(REG_BOX_MIN_Y, ly);
    write_corner(REG_BOX_MIN_Z, lz);
    write_corner(REG_BOX_MAX_X, hx);
    write_corner(REG_BOX_MAX_Y, hy);
    write_corner(REG_BOX_MAX_Z, hz);
  endtask

  // Drives one ray beat and holds it until accepted.
  task automatic send_ray(ray_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      ray_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    ray_ch.valid <= 1'b1;
    {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} <= {r.ox, r.oy, r.oz};
    {ray_ch.direction_x, ray_ch.direction_y, ray_ch.direction_z} <= {r.dx, r.dy, r.dz};
    ray_ch.far_limit <= r.lim;
    do @(posedge clk_i); while (!ray_ch.ready);
    pending_hits.push_back(predict_hit(r));
    rays_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && hit_ch.valid && hit_ch.ready) begin
      hit_t got, want;
      got.hit = hit_ch.hit_flag;
      got.distance = hit_ch.hit_distance;
      hits_seen++;
      if (got.hit) hit_count++;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected hit beat hit=%0b distance=%0d", $time, got.hit,
                 got.distance);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit_flag expected %0b actual %0b", $time, want.hit, got.hit);
          errors++;
        end
        if (got.distance !== want.distance) begin
          $display("%0t: hit_distance expected %0d actual %0d", $time, want.distance,
                   got.distance);
          errors++;
        end
      end
    end
  end

  // Output stall bursts.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && hit_ch.ready && $urandom_range(0, 6) == 0) begin
        gap = $urandom_range(1, 11);
        hit_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      hit_ch.ready <= 1'b1;
    end
  end

  function automatic logic signed [31:0] rand_q(int span);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return $urandom();
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic ray_t rand_ray(int span);
    ray_t r;
    r.ox = rand_q(span); r.oy = rand_q(span); r.oz = rand_q(span);
    r.dx = rand_q(span); r.dy = rand_q(span); r.dz = rand_q(span);
    r.lim = $urandom_range(0, 3) == 0 ? rand_q(span) : 32'sh7FFF_FFFF;
    return r;
  endfunction

  // Rays aimed at the box center, so hits are common.
  function automatic ray_t aimed_ray(int span);
    ray_t r;
    r.ox = $signed($urandom_range(0, 8 * span)) - 4 * span;
    r.oy = $signed($urandom_range(0, 8 * span)) - 4 * span;
    r.oz = $signed($urandom_range(0, 8 * span)) - 4 * span;
    r.dx = ((box_lo[0] >>> 1) + (box_hi[0] >>> 1) - r.ox) >>> 2;
    r.dy = ((box_lo[1] >>> 1) + (box_hi[1] >>> 1) - r.oy) >>> 2;
    r.dz = ((box_lo[2] >>> 1) + (box_hi[2] >>> 1) - r.oz) >>> 2;
    r.lim = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : $signed($urandom_range(0, 32'h0010_0000));
    return r;
  endfunction

  task automatic test_directed();
    ray_t r;
    set_box(-32'sh1_0000, -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
    // Along x from outside, diagonally from inside, and along x pointing away.
    send_ray('{-32'sh5_0000, 0, 0, 32'sh1_0000, 0, 0, 32'sh7FFF_FFFF});
    send_ray('{0, 0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh7FFF_FFFF});
    send_ray('{32'sh5_0000, 0, 0, 32'sh1_0000, 0, 0, 32'sh7FFF_FFFF});
    // Entry past the far limit.
    send_ray('{-32'sh5_0000, 0, 0, 32'sh1_0000, 0, 0, 32'sh1_0000});
    // Direction of minus one LSB makes a zero divisor, with numerators of each sign.
    send_ray('{-32'sh5_0000, 0, 0, 32'sh1_0000, -32'sd1, -32'sd1, 32'sh7FFF_FFFF});
    send_ray('{-32'sh5_0000, 32'sh5_0000, 0, 32'sh1_0000, -32'sd1, 0, 32'sh7FFF_FFFF});
    // Extremes saturate the quotients.
    send_ray('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, 32'sd0, 32'sh7FFF_FFFF,
               32'sh8000_0000});
    send_ray('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
               -32'sd2, 32'sh7FFF_FFFF});
    send_ray('{0, 0, 0, 0, 0, 0, 0});
    send_ray('{-1, -1, -1, -1, -1, -1, -1});
    // Inverted box: corners swapped.
    set_box(32'sh1_0000, 32'sh1_0000, 32'sh1_0000, -32'sh1_0000, -32'sh1_0000, -32'sh1_0000);
    send_ray('{-32'sh5_0000, 0, 0, 32'sh1_0000, 0, 0, 32'sh7FFF_FFFF});
    send_ray('{0, 0, 0, -32'sh2_0000, 32'sh3000, 32'sh100, 32'sh1000});
    // Register extremes.
    set_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    for (int i = 0; i < 8; i++) begin
      r = rand_ray(32'h0004_0000);
      send_ray(r);
    end
  endtask

  task automatic test_random(int n, int span);
    ray_t r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 2) == 0 ? rand_ray(span) : aimed_ray(span);
      send_ray(r);
    end
  endtask

  task automatic test_random_boxes();
    logic signed [31:0] c [6];
    for (int k = 0; k < 5; k++) begin
      for (int j = 0; j < 3; j++) begin
        c[j] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        c[j + 3] = c[j] + $signed($urandom_range(0, 32'h0004_0000));
      end
      if (k == 4) c[0] = $urandom();
      set_box(c[0], c[1], c[2], c[3], c[4], c[5]);
      test_random(90, 32'h0008_0000);
    end
  endtask

  task automatic test_full_rate();
    set_box(-32'sh2_0000, -32'sh3_0000, -32'sh1000, 32'sh4_0000, 32'sh1_0000, 32'sh5_0000);
    quiet = 1'b1;
    test_random(80, 32'h0008_0000);
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = '0;
      box_hi[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_boxes();
    test_full_rate();
    drain();
    $display("Sent %0d rays, checked %0d results, %0d of them hits.",
             rays_sent, hits_seen, hit_count);
    $display("Covered directed edges, inverted and extreme boxes, random boxes, full rate.");
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
